/* rtl/core/assert_macros.svh */
// Assertion macros for the checker module of the bank switch block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk_i edge outside reset.
`define LCBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent on the same edge.
`define LCBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lcbs_pkg.sv */
// Shared types and constants of the language card bank switch.
`default_nettype none

package lcbs_pkg;

  // Transaction opcodes
  localparam logic [2:0] OpSwRead   = 3'd0;
  localparam logic [2:0] OpSwWrite  = 3'd1;
  localparam logic [2:0] OpBankRead = 3'd2;
  localparam logic [2:0] OpBankWrite = 3'd3;
  localparam logic [2:0] OpRomLoad  = 3'd4;

  // Address map
  localparam logic [15:0] BankBase = 16'hD000;
  localparam logic [3:0]  BankNib  = 4'hD;
  localparam logic [2:0]  UpperTop = 3'b111;

  // Unified RAM: bank 2 at 0, bank 1 at 4K, upper RAM at 8K
  localparam int unsigned RamIdxW  = 14;
  localparam int unsigned RomOffW  = 14;
  localparam int unsigned CfgW     = 14;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ram_read_mode;
    logic       ram_write_mode;
    logic       bank_two_active;
    logic       write_armed;
  } out_t;

  typedef struct packed {
    logic read_ram;
    logic write_ram;
    logic prewrite;
    logic bank_two;
  } flags_t;

  typedef struct packed {
    logic               ram_we;
    logic               ram_re;
    logic [RamIdxW-1:0] ram_idx;
    logic               rom_we;
    logic               rom_re;
    logic [RomOffW-1:0] rom_off;
  } mem_req_t;

  typedef enum logic [1:0] {
    RdZero = 2'd0,
    RdOnes = 2'd1,
    RdRam  = 2'd2,
    RdRom  = 2'd3
  } rd_sel_e;

endpackage

`default_nettype wire

/* rtl/core/lcbs_switch.sv */
// Soft switch decoder and mode flag registers.
`default_nettype none

module lcbs_switch (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            touch_i,
  input  wire logic [3:0]      sw_i,
  output lcbs_pkg::flags_t     flags_o
);

  lcbs_pkg::flags_t flags_d, flags_q;
  logic [3:0]       last_sw_d, last_sw_q;

  // Decode one switch access
  always_comb begin
    flags_d   = flags_q;
    last_sw_d = last_sw_q;
    if (touch_i) begin
      flags_d.bank_two = ~sw_i[3];
      flags_d.read_ram = (sw_i[1:0] == 2'b00) || (sw_i[1:0] == 2'b11);
      if (sw_i[0]) begin
        // Second hit on the same odd switch enables writes
        if (flags_q.prewrite && (last_sw_q == sw_i)) begin
          flags_d.write_ram = 1'b1;
        end else begin
          flags_d.prewrite = 1'b1;
        end
      end else begin
        flags_d.write_ram = 1'b0;
        flags_d.prewrite  = 1'b0;
      end
      last_sw_d = sw_i;
    end
  end

  // Hold flags across transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q   <= '{read_ram: 1'b0, write_ram: 1'b0, prewrite: 1'b0, bank_two: 1'b1};
      last_sw_q <= '0;
    end else begin
      flags_q   <= flags_d;
      last_sw_q <= last_sw_d;
    end
  end

  assign flags_o = flags_q;

endmodule

`default_nettype wire

/* rtl/core/lcbs_mem.sv */
// RAM and ROM stores with the post-reset RAM clearing pass.
`default_nettype none

module lcbs_mem #(
  parameter int unsigned ROM_BYTES = 12288
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lcbs_pkg::mem_req_t req_i,
  input  wire logic [7:0]         wdata_i,
  output logic [7:0]              ram_rdata_o,
  output logic [7:0]              rom_rdata_o,
  output logic                    clearing_o
);

  localparam int unsigned RamDepth = 2 ** lcbs_pkg::RamIdxW;
  localparam int unsigned RomAw    = (ROM_BYTES > 1) ? $clog2(ROM_BYTES) : 1;

  typedef enum logic [1:0] {
    MemClear = 2'b01,
    MemRun   = 2'b10
  } mem_state_e;

  mem_state_e                   state_d, state_q;
  logic [lcbs_pkg::RamIdxW-1:0] clr_cnt_d, clr_cnt_q;
  logic                         ram_wen;
  logic [lcbs_pkg::RamIdxW-1:0] ram_widx;
  logic [7:0]                   ram_wdata;

  logic [7:0] ram_q [RamDepth];
  logic [7:0] rom_q [ROM_BYTES];
  logic [7:0] ram_rdata_q, rom_rdata_q;

  // Sweep every RAM entry once after reset
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      MemClear: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = MemRun;
        end
      end
      MemRun: begin
        state_d = MemRun;
      end
      default: begin
        state_d = MemClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= MemClear;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign clearing_o = (state_q != MemRun);

  // Share the RAM write port between the sweep and bank writes
  assign ram_wen   = clearing_o || req_i.ram_we;
  assign ram_widx  = clearing_o ? clr_cnt_q : req_i.ram_idx;
  assign ram_wdata = clearing_o ? 8'h00 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (ram_wen) begin
      ram_q[ram_widx] <= ram_wdata;
    end
    if (req_i.ram_re) begin
      ram_rdata_q <= ram_q[req_i.ram_idx];
    end
  end

  // ROM store: loaded and read at an in-range offset only
  always_ff @(posedge clk_i) begin
    if (req_i.rom_we) begin
      rom_q[req_i.rom_off[RomAw-1:0]] <= wdata_i;
    end
    if (req_i.rom_re) begin
      rom_rdata_q <= rom_q[req_i.rom_off[RomAw-1:0]];
    end
  end

  assign ram_rdata_o = ram_rdata_q;
  assign rom_rdata_o = rom_rdata_q;

endmodule

`default_nettype wire

/* rtl/core/language_card_bank_switch.sv */
// Top level of the language card bank switch.
//
// Usage: drive a transaction on item_i with start high; it is taken at a
// rising edge where busy is low. Each transaction yields one result on
// result_o, marked by done_o for exactly one cycle; the receiver cannot
// stall, so results must be captured when done_o is high.
// An accepted transaction passes the input register, then the memory and
// flag update registers, before done_o rises. Throughput: one transaction
// per cycle while busy is low; each transaction uses the RAM and the ROM
// at most once.
// Mode flags in the result are the values after the transaction.
// rom_size is written through cfg_we_i / cfg_wdata_i; the user must do so
// while idle, as the block does not enforce it. Reset: flags return to ROM
// reads, writes off, bank 2 mapped. After reset release busy stays high while
// the RAM is cleared one byte per cycle; configuration writes are taken then.
`default_nettype none

module language_card_bank_switch #(
  parameter int unsigned ROM_BYTES = 12288
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire lcbs_pkg::in_t                item_i,
  output logic                              done_o,
  output lcbs_pkg::out_t                    result_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [lcbs_pkg::CfgW-1:0]    cfg_wdata_i
);

  localparam logic [lcbs_pkg::CfgW-1:0] RomCap = lcbs_pkg::CfgW'(ROM_BYTES);
  localparam logic [15:0]               RomEnd = 16'(ROM_BYTES);

  logic                       clearing;
  logic                       accept;
  logic                       s1_valid_q, s2_valid_q;
  lcbs_pkg::in_t              s1_item_q;
  lcbs_pkg::rd_sel_e          rd_sel_d, rd_sel_q;
  logic [lcbs_pkg::CfgW-1:0]  rom_size_q;
  logic [lcbs_pkg::CfgW-1:0]  rom_limit;
  logic [15:0]                rom_off;
  logic                       above_base, in_bank, in_upper, rom_hit;
  logic                       touch;
  lcbs_pkg::flags_t           flags;
  lcbs_pkg::mem_req_t         req;
  logic [7:0]                 ram_rdata, rom_rdata;

  assign busy   = clearing;
  assign accept = start && !busy;

  // Capture configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_size_q <= '0;
    end else if (cfg_we_i) begin
      rom_size_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item_i;
    end
  end

  // Decode the registered transaction
  assign above_base = (s1_item_q.address >= lcbs_pkg::BankBase);
  assign in_bank    = (s1_item_q.address[15:12] == lcbs_pkg::BankNib);
  assign in_upper   = (s1_item_q.address[15:13] == lcbs_pkg::UpperTop);
  assign rom_off    = s1_item_q.address - lcbs_pkg::BankBase;
  assign rom_limit  = (rom_size_q > RomCap) ? RomCap : rom_size_q;
  assign rom_hit    = above_base && (rom_off < {2'b00, rom_limit});
  assign touch      = s1_valid_q && ((s1_item_q.opcode == lcbs_pkg::OpSwRead) ||
                                     (s1_item_q.opcode == lcbs_pkg::OpSwWrite));

  always_comb begin
    req          = '0;
    req.ram_idx  = in_upper ? {1'b1, s1_item_q.address[12:0]}
                            : {1'b0, ~flags.bank_two, s1_item_q.address[11:0]};
    req.rom_off  = rom_off[lcbs_pkg::RomOffW-1:0];
    rd_sel_d     = lcbs_pkg::RdZero;
    if (s1_valid_q) begin
      case (s1_item_q.opcode)
        lcbs_pkg::OpBankRead: begin
          if (flags.read_ram) begin
            if (in_bank || in_upper) begin
              req.ram_re = 1'b1;
              rd_sel_d   = lcbs_pkg::RdRam;
            end else begin
              rd_sel_d   = lcbs_pkg::RdOnes;
            end
          end else if (rom_hit) begin
            req.rom_re = 1'b1;
            rd_sel_d   = lcbs_pkg::RdRom;
          end else begin
            rd_sel_d   = lcbs_pkg::RdOnes;
          end
        end
        lcbs_pkg::OpBankWrite: begin
          req.ram_we = flags.write_ram && (in_bank || in_upper);
        end
        lcbs_pkg::OpRomLoad: begin
          req.rom_we = above_base && (rom_off < RomEnd);
        end
        default: begin
          rd_sel_d = lcbs_pkg::RdZero;
        end
      endcase
    end
  end

  lcbs_switch u_switch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .touch_i (touch),
    .sw_i    (s1_item_q.address[3:0]),
    .flags_o (flags)
  );

  lcbs_mem #(
    .ROM_BYTES (ROM_BYTES)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .wdata_i     (s1_item_q.write_data),
    .ram_rdata_o (ram_rdata),
    .rom_rdata_o (rom_rdata),
    .clearing_o  (clearing)
  );

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      rd_sel_q   <= lcbs_pkg::RdZero;
    end else begin
      s2_valid_q <= s1_valid_q;
      rd_sel_q   <= rd_sel_d;
    end
  end

  // Select the read byte; flags already hold post-transaction values
  always_comb begin
    case (rd_sel_q)
      lcbs_pkg::RdOnes: result_o.read_data = 8'hFF;
      lcbs_pkg::RdRam:  result_o.read_data = ram_rdata;
      lcbs_pkg::RdRom:  result_o.read_data = rom_rdata;
      default:          result_o.read_data = 8'h00;
    endcase
    result_o.ram_read_mode   = flags.read_ram;
    result_o.ram_write_mode  = flags.write_ram;
    result_o.bank_two_active = flags.bank_two;
    result_o.write_armed     = flags.prewrite;
  end

  assign done_o = s2_valid_q;

endmodule

`default_nettype wire

/* rtl/core/lcbs_checker.sv */
// Port-level checker for the language card bank switch, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module lcbs_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire lcbs_pkg::in_t  item_i,
  input wire lcbs_pkg::out_t result_o
);

  logic take;
  logic take_switch;

  assign take        = start && !busy;
  assign take_switch = take && ((item_i.opcode == lcbs_pkg::OpSwRead) ||
                                (item_i.opcode == lcbs_pkg::OpSwWrite));

  `LCBS_ASSERT(a_result_follows, take |-> ##2 done_o, "accepted transaction gave no result")
  `LCBS_ASSERT(a_no_spurious, done_o |-> $past(take, 2), "result without a transaction")
  `LCBS_ASSERT(a_busy_once, !busy |=> !busy, "busy returned after the clearing pass")
  `LCBS_ASSERT_IMP(a_write_needs_arm, done_o && result_o.ram_write_mode,
                   result_o.write_armed, "write enable without armed flag")
  `LCBS_ASSERT(a_switch_reads_zero, take_switch |-> ##2 (result_o.read_data == 8'h00),
               "switch access returned nonzero data")

endmodule

bind language_card_bank_switch lcbs_checker u_lcbs_checker (.*);

`default_nettype wire
